// ----- design/lsvm_pkg.sv -----
package lsvm_pkg;

  localparam int MAX_VOICES    = 64;
  localparam int CHUNK_SAMPLES = 64;
  localparam int SAMPLE_WORDS  = 65536;
  localparam int SOUND_SLOTS   = 256;

  localparam int VIDX_W  = $clog2(MAX_VOICES);
  localparam int CNT_W   = 7;
  localparam int PH_W    = (CHUNK_SAMPLES > 1) ? $clog2(CHUNK_SAMPLES) : 1;
  localparam int SADDR_W = $clog2(SAMPLE_WORDS);
  localparam int SND_W   = $clog2(SOUND_SLOTS);

  localparam int SIZE_W  = 17;
  localparam int POS_W   = 33;
  localparam int STEP_W  = 24;
  localparam int ACC_W   = 38;
  localparam int PROD_W  = 33;

  // wrap search: position stays below size * 2^16 * 257
  localparam int MOD_STEPS = 9;
  localparam int MOD_W     = POS_W + MOD_STEPS - 1;
  localparam int MODK_W    = $clog2(MOD_STEPS);

  localparam logic [SIZE_W-1:0] MAX_LEN = 17'h10000;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    ACT_LOAD   = 3'd0,
    ACT_DEFINE = 3'd1,
    ACT_START  = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_GAINS  = 3'd4,
    ACT_TICK   = 3'd5
  } action_t;

  typedef struct packed {
    logic [15:0]       tag;
    logic [15:0]       base;
    logic [SIZE_W-1:0] size;
    logic [POS_W-1:0]  pos;
    logic [STEP_W-1:0] step;
    logic [15:0]       gain_l;
    logic [15:0]       gain_r;
    logic              loop_en;
    logic [15:0]       gap;
    logic [15:0]       gap_left;
    logic              stopping;
  } voice_t;

  typedef struct packed {
    logic [15:0]       base;
    logic [SIZE_W-1:0] size;
  } sound_t;

endpackage

// ----- design/looping_sample_voice_mixer.sv -----
// channel  | direction | tdata                                     | tuser
// in_      | slave     | address, sample, sound id, length, tag,   | action
//          |           | step, gains, loop flag, gap               |
// out_     | master    | left, right, clipped, active, dropped     | -
// load, define, unknown actions and a dropped start go straight to the result, a start
// first reads the sound table and then writes the voice record; stop and set gains
// read every occupied slot, a tick also fetches, scales and writes back each playing
// voice, with a modulo search for a voice that wraps past its end
// every 64th tick adds a freeing sweep over all slots
// rst_n clears slot valid bits, sound defined bits, count and chunk phase
// one result is held while the next beat is accepted and worked on
module looping_sample_voice_mixer
  import lsvm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // address[15:0] sample_value[31:16] sound_id[39:32] sound_length[56:40]
  // voice_tag[72:57] step[96:73] left_gain[112:97] right_gain[128:113]
  // loop_enable[129] loop_gap[145:130]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]            in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // left_out[15:0] right_out[31:16] clipped[32] active_voices[39:33]
  // start_dropped[40]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_SWP_RD, S_SWP_EV, S_MOD, S_PLAY, S_MUL, S_ACC,
    S_FR_RD, S_FR_EV, S_ST_WR, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [15:0] smp_mem [SAMPLE_WORDS];
  sound_t      snd_mem [SOUND_SLOTS];
  voice_t      rec_mem [MAX_VOICES];

  logic [15:0] smp_q;
  sound_t      snd_q;
  voice_t      rec_q;

  logic               smp_we, smp_re, snd_we, snd_re, rec_we, rec_re;
  logic [SADDR_W-1:0] smp_wa, smp_ra;
  logic [15:0]        smp_wd;
  logic [SND_W-1:0]   snd_a;
  sound_t             snd_wd;
  logic [VIDX_W-1:0]  rec_wa, rec_ra;
  voice_t             rec_wd;

  always_ff @(posedge clk) begin
    if (smp_we) smp_mem[smp_wa] <= smp_wd;
    if (smp_re) smp_q <= smp_mem[smp_ra];
  end

  always_ff @(posedge clk) begin
    if (snd_we) snd_mem[snd_a] <= snd_wd;
    if (snd_re) snd_q <= snd_mem[snd_a];
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (rec_re) rec_q <= rec_mem[rec_ra];
  end

  // input fields
  logic [IN_DATA_W-1:0] in_r, in_nxt;
  action_t              act_r, act_nxt;
  logic [15:0]       f_addr, f_smp, f_tag, f_gl, f_gr, f_gap;
  logic [7:0]        f_id;
  logic [SIZE_W-1:0] f_len;
  logic [STEP_W-1:0] f_step;
  logic              f_loop;

  assign f_addr = in_r[15:0];
  assign f_smp  = in_r[31:16];
  assign f_id   = in_r[39:32];
  assign f_len  = in_r[56:40];
  assign f_tag  = in_r[72:57];
  assign f_step = in_r[96:73];
  assign f_gl   = in_r[112:97];
  assign f_gr   = in_r[128:113];
  assign f_loop = in_r[129];
  assign f_gap  = in_r[145:130];

  logic [MAX_VOICES-1:0]  valid_r, valid_nxt;
  logic [SOUND_SLOTS-1:0] sdef_r, sdef_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [PH_W-1:0]        phase_r, phase_nxt;
  logic [VIDX_W-1:0]      v_r, v_nxt, free_r, free_nxt;
  logic [MODK_W-1:0]      k_r, k_nxt;
  voice_t                 wrk_r, wrk_nxt;
  logic                   oob_r, oob_nxt;
  logic signed [PROD_W-1:0] pl_r, pl_nxt, pr_r, pr_nxt;
  logic signed [ACC_W-1:0]  accl_r, accl_nxt, accr_r, accr_nxt;
  logic [15:0]  resl_r, resl_nxt, resr_r, resr_nxt;
  logic         clip_r, clip_nxt, drop_r, drop_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_r, out_nxt;

  // helpers
  logic [SIZE_W-1:0]  idx;
  logic               past_end;
  logic [SADDR_W+1:0] smp_sum;
  logic [MOD_W-1:0]   mod_d;
  logic               free_found;
  logic [VIDX_W-1:0]  free_idx;
  logic signed [16:0] smp_s;
  logic signed [ACC_W-1:0] tl, tr;
  logic signed [ACC_W-16:0] ql, qr;
  logic               last_v;
  logic               in_acc;

  assign idx      = rec_q.pos[POS_W-1:16];
  assign past_end = idx >= rec_q.size;
  assign last_v   = (v_r == VIDX_W'(MAX_VOICES - 1));
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_VOICES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = VIDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_nxt = in_r;
    act_nxt = act_r;
    valid_nxt = valid_r;
    sdef_nxt = sdef_r;
    cnt_nxt = cnt_r;
    phase_nxt = phase_r;
    v_nxt = v_r;
    free_nxt = free_r;
    k_nxt = k_r;
    wrk_nxt = wrk_r;
    oob_nxt = oob_r;
    pl_nxt = pl_r;
    pr_nxt = pr_r;
    accl_nxt = accl_r;
    accr_nxt = accr_r;
    resl_nxt = resl_r;
    resr_nxt = resr_r;
    clip_nxt = clip_r;
    drop_nxt = drop_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    smp_we = 1'b0; smp_re = 1'b0; smp_wa = f_addr[SADDR_W-1:0]; smp_wd = f_smp;
    smp_sum = {2'b0, wrk_r.base} + {1'b0, wrk_r.pos[POS_W-1:16]};
    smp_ra = smp_sum[SADDR_W-1:0];
    snd_we = 1'b0; snd_re = 1'b0; snd_a = f_id[SND_W-1:0];
    snd_wd.base = f_addr;
    snd_wd.size = (f_len > MAX_LEN) ? MAX_LEN : f_len;
    rec_we = 1'b0; rec_re = 1'b0; rec_wa = v_r; rec_ra = v_r; rec_wd = rec_q;
    mod_d = MOD_W'({wrk_r.size, 16'b0}) << k_r;
    smp_s = oob_r ? 17'sd0 : 17'(signed'(smp_q));
    tl = accl_r + ACC_W'(16384);
    tr = accr_r + ACC_W'(16384);
    ql = tl[ACC_W-1:15];
    qr = tr[ACC_W-1:15];

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          in_nxt   = in_tdata;
          act_nxt  = action_t'(in_tuser);
          accl_nxt = '0;
          accr_nxt = '0;
          resl_nxt = '0;
          resr_nxt = '0;
          clip_nxt = 1'b0;
          drop_nxt = 1'b0;
          v_nxt    = '0;
          free_nxt = free_idx;
          case (in_tuser)
            ACT_LOAD: begin
              smp_we = 1'b1;
              smp_wa = in_tdata[SADDR_W-1:0];
              smp_wd = in_tdata[31:16];
              state_nxt = S_DONE;
            end
            ACT_DEFINE: begin
              snd_we = 1'b1;
              snd_a  = in_tdata[32 +: SND_W];
              snd_wd.base = in_tdata[15:0];
              snd_wd.size = (in_tdata[56:40] > MAX_LEN) ? MAX_LEN : in_tdata[56:40];
              sdef_nxt[in_tdata[32 +: SND_W]] = (in_tdata[56:40] != '0);
              state_nxt = S_DONE;
            end
            ACT_START: begin
              snd_a = in_tdata[32 +: SND_W];
              if (!sdef_r[in_tdata[32 +: SND_W]] || !free_found) begin
                drop_nxt  = 1'b1;
                state_nxt = S_DONE;
              end else begin
                snd_re    = 1'b1;
                state_nxt = S_ST_WR;
              end
            end
            ACT_STOP, ACT_GAINS, ACT_TICK: state_nxt = S_SWP_RD;
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_ST_WR: begin
        rec_we = 1'b1;
        rec_wa = free_r;
        rec_wd.tag = f_tag;
        rec_wd.base = snd_q.base;
        rec_wd.size = snd_q.size;
        rec_wd.pos = '0;
        rec_wd.step = f_step;
        rec_wd.gain_l = f_gl;
        rec_wd.gain_r = f_gr;
        rec_wd.loop_en = f_loop;
        rec_wd.gap = f_gap;
        rec_wd.gap_left = '0;
        rec_wd.stopping = 1'b0;
        valid_nxt[free_r] = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = S_DONE;
      end

      S_SWP_RD: begin
        if (valid_r[v_r]) begin
          rec_re = 1'b1;
          state_nxt = S_SWP_EV;
        end else begin
          state_nxt = S_ACC;  // skip: accumulate nothing
          pl_nxt = '0;
          pr_nxt = '0;
        end
      end

      S_SWP_EV: begin
        rec_wd  = rec_q;
        wrk_nxt = rec_q;
        pl_nxt  = '0;
        pr_nxt  = '0;
        state_nxt = S_ACC;
        case (act_r)
          ACT_STOP: begin
            if (rec_q.tag == f_tag) begin
              rec_wd.stopping = 1'b1;
              rec_we = 1'b1;
            end
          end
          ACT_GAINS: begin
            if (rec_q.tag == f_tag && !(!rec_q.loop_en && past_end)) begin
              rec_wd.gain_l = f_gl;
              rec_wd.gain_r = f_gr;
              rec_we = 1'b1;
            end
          end
          default: begin
            if (rec_q.loop_en && rec_q.gap_left != '0) begin
              rec_wd.gap_left = rec_q.gap_left - 1'b1;
              rec_we = 1'b1;
            end else if (past_end) begin
              if (rec_q.loop_en && rec_q.gap != '0) begin
                rec_wd.gap_left = rec_q.gap;
                rec_wd.pos = '0;
                rec_we = 1'b1;
              end else if (rec_q.loop_en && rec_q.size != '0) begin
                k_nxt = MODK_W'(MOD_STEPS - 1);
                state_nxt = S_MOD;
              end
            end else begin
              state_nxt = S_PLAY;
            end
          end
        endcase
      end

      S_MOD: begin
        if (MOD_W'(wrk_r.pos) >= mod_d)
          wrk_nxt.pos = wrk_r.pos - POS_W'(mod_d);
        if (k_r == '0) state_nxt = S_PLAY;
        else k_nxt = k_r - 1'b1;
      end

      S_PLAY: begin
        smp_re  = 1'b1;
        oob_nxt = (smp_sum >= (SADDR_W+2)'(SAMPLE_WORDS));
        wrk_nxt.pos = wrk_r.pos + POS_W'(wrk_r.step);
        state_nxt = S_MUL;
      end

      S_MUL: begin
        rec_we = 1'b1;
        rec_wd = wrk_r;
        pl_nxt = PROD_W'(smp_s * $signed({1'b0, wrk_r.gain_l}));
        pr_nxt = PROD_W'(smp_s * $signed({1'b0, wrk_r.gain_r}));
        state_nxt = S_ACC;
      end

      S_ACC: begin
        accl_nxt = accl_r + ACC_W'(pl_r);
        accr_nxt = accr_r + ACC_W'(pr_r);
        if (!last_v) begin
          v_nxt = v_r + 1'b1;
          state_nxt = S_SWP_RD;
        end else if (act_r != ACT_TICK) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DONE;
          v_nxt = '0;
          // round and saturate using the final sums
          tl = accl_nxt + ACC_W'(16384);
          tr = accr_nxt + ACC_W'(16384);
          ql = tl[ACC_W-1:15];
          qr = tr[ACC_W-1:15];
          if (ql > 23'sd32767) begin
            resl_nxt = 16'h7FFF; clip_nxt = 1'b1;
          end else if (ql < -23'sd32768) begin
            resl_nxt = 16'h8000; clip_nxt = 1'b1;
          end else resl_nxt = ql[15:0];
          if (qr > 23'sd32767) begin
            resr_nxt = 16'h7FFF; clip_nxt = 1'b1;
          end else if (qr < -23'sd32768) begin
            resr_nxt = 16'h8000; clip_nxt = 1'b1;
          end else resr_nxt = qr[15:0];
          if (phase_r == PH_W'(CHUNK_SAMPLES - 1)) begin
            phase_nxt = '0;
            state_nxt = S_FR_RD;
          end else begin
            phase_nxt = phase_r + 1'b1;
          end
        end
      end

      S_FR_RD: begin
        if (valid_r[v_r]) begin
          rec_re = 1'b1;
          state_nxt = S_FR_EV;
        end else if (last_v) begin
          state_nxt = S_DONE;
        end else begin
          v_nxt = v_r + 1'b1;
        end
      end

      S_FR_EV: begin
        if (rec_q.stopping || (!rec_q.loop_en && past_end)) begin
          valid_nxt[v_r] = 1'b0;
          cnt_nxt = cnt_r - 1'b1;
        end
        if (last_v) state_nxt = S_DONE;
        else begin
          v_nxt = v_r + 1'b1;
          state_nxt = S_FR_RD;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_nxt = {7'b0, drop_r, cnt_r, clip_r, resr_r, resl_r};
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      sdef_r      <= '0;
      cnt_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      sdef_r      <= sdef_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_r   <= in_nxt;
    act_r  <= act_nxt;
    v_r    <= v_nxt;
    free_r <= free_nxt;
    k_r    <= k_nxt;
    wrk_r  <= wrk_nxt;
    oob_r  <= oob_nxt;
    pl_r   <= pl_nxt;
    pr_r   <= pr_nxt;
    accl_r <= accl_nxt;
    accr_r <= accr_nxt;
    resl_r <= resl_nxt;
    resr_r <= resr_nxt;
    clip_r <= clip_nxt;
    drop_r <= drop_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ----- design/lsvm_chk.sv -----
module lsvm_chk
  import lsvm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // clipped comes only from a tick and start_dropped only from a start, never both flags
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[32] && out_tdata[40]))
    else $error("clipped and start_dropped together");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] <= 7'(MAX_VOICES))
    else $error("active voice count out of range");

  // one item at a time: no accept right after another accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

endmodule

bind looping_sample_voice_mixer lsvm_chk u_lsvm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
